// ----- src/lba_pkg.sv -----
// Shared types and constants for the lamp brightness animator.
// Holds the event and lamp state structs, the op and mode codes, and the step sizes.
// No dependencies.
`default_nettype none

package lba_pkg;

  // Event op codes
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_LEVEL  = 3'd1,
    OP_SET_MODE   = 3'd2,
    OP_SET_DIR    = 3'd3,
    OP_TOGGLE_DIR = 3'd4
  } op_t;

  // Animation modes
  typedef enum logic [2:0] {
    MODE_STABLE  = 3'd0,
    MODE_TINY    = 3'd1,
    MODE_SMALL   = 3'd2,
    MODE_LARGE   = 3'd3,
    MODE_HUGE    = 3'd4,
    MODE_FLICKER = 3'd5,
    MODE_PULSE   = 3'd6,
    MODE_RIPPLE  = 3'd7
  } mode_t;

  // Fine step sizes in 1/16 level units
  localparam logic [8:0] STEP_TINY  = 9'd1;
  localparam logic [8:0] STEP_SMALL = 9'd2;
  localparam logic [8:0] STEP_LARGE = 9'd32;
  localparam logic [8:0] STEP_HUGE  = 9'd256;

  localparam logic [7:0] LEVEL_FULL  = 8'd255;
  localparam logic [7:0] LEVEL_ZERO  = 8'd0;
  localparam logic [7:0] RIPPLE_BAND = 8'd64;

  // Lamp state: 8-bit level plus 4 fraction bits, mode and direction
  typedef struct packed {
    logic [11:0] fine;
    mode_t       mode;
    logic        dim;
  } lamp_state_t;

  // One event as captured from the input channel
  typedef struct packed {
    op_t        op;
    logic [7:0] level;
    mode_t      mode;
    logic       dir;
    logic [7:0] floor_lvl;
    logic [7:0] ceil_lvl;
  } event_t;

endpackage

`default_nettype wire

// ----- src/lba_core.sv -----
// Next-state logic of the lamp animator: applies one event to the lamp state.
// Purely combinational; uses lba_pkg for the event and state types.
`default_nettype none

module lba_core (
  input  lba_pkg::lamp_state_t state_i,
  input  lba_pkg::event_t      event_i,
  input  logic [7:0]           ref_level,
  output lba_pkg::lamp_state_t state_o
);

  // Move the fine value one step and clamp to the floor or ceiling level.
  function automatic logic [11:0] step_fine(input logic [11:0] fine, input logic dim,
                                            input logic [8:0] size, input logic [7:0] lo,
                                            input logic [7:0] hi);
    logic [12:0] sum;
    logic [12:0] diff;
    logic [11:0] res;
    sum  = {1'b0, fine} + {4'b0, size};
    diff = {1'b0, fine} - {4'b0, size};
    if (dim) begin
      // A borrow means the value went below zero, which is below any floor.
      if (diff[12] || (diff[11:0] < {lo, 4'b0})) begin
        res = {lo, 4'b0};
      end else begin
        res = diff[11:0];
      end
    end else begin
      if (sum > {1'b0, hi, 4'b0}) begin
        res = {hi, 4'b0};
      end else begin
        res = sum[11:0];
      end
    end
    return res;
  endfunction

  localparam logic [7:0] RIPPLE_BAND_W = lba_pkg::RIPPLE_BAND;

  logic [7:0]  level;
  logic [15:0] flick_w0;
  logic [15:0] flick_w1;
  logic [15:0] flick_w2;
  logic [8:0]  ripple_hi;
  logic        ripple_up_turn;
  logic        ripple_down_turn;
  logic        ripple_dim;

  assign level = state_i.fine[11:4];

  // Flicker scrambles the level with an xorshift over the whole state word.
  assign flick_w0 = {state_i.dim, state_i.mode, state_i.fine};
  assign flick_w1 = flick_w0 ^ {flick_w0[10:0], 5'b0};
  assign flick_w2 = flick_w1 ^ {7'b0, flick_w1[15:7]};

  // Ripple turns around when it leaves the band around the reference level.
  assign ripple_hi        = {1'b0, ref_level} + {1'b0, RIPPLE_BAND_W};
  assign ripple_up_turn   = ({1'b0, level} > ripple_hi) && !state_i.dim;
  assign ripple_dim       = state_i.dim ^ ripple_up_turn;
  assign ripple_down_turn = (ref_level >= lba_pkg::RIPPLE_BAND)
                            && (level < (ref_level - lba_pkg::RIPPLE_BAND)) && ripple_dim;

  // Event decode and tick animation
  always_comb begin
    state_o = state_i;
    unique case (event_i.op)
      lba_pkg::OP_TICK: begin
        unique case (state_i.mode)
          lba_pkg::MODE_STABLE: ;
          lba_pkg::MODE_TINY:
            state_o.fine = step_fine(state_i.fine, state_i.dim, lba_pkg::STEP_TINY,
                                     event_i.floor_lvl, event_i.ceil_lvl);
          lba_pkg::MODE_SMALL:
            state_o.fine = step_fine(state_i.fine, state_i.dim, lba_pkg::STEP_SMALL,
                                     event_i.floor_lvl, event_i.ceil_lvl);
          lba_pkg::MODE_LARGE:
            state_o.fine = step_fine(state_i.fine, state_i.dim, lba_pkg::STEP_LARGE,
                                     event_i.floor_lvl, event_i.ceil_lvl);
          lba_pkg::MODE_HUGE:
            state_o.fine = step_fine(state_i.fine, state_i.dim, lba_pkg::STEP_HUGE,
                                     event_i.floor_lvl, event_i.ceil_lvl);
          lba_pkg::MODE_FLICKER:
            state_o.fine = {flick_w2[11:4], state_i.fine[3:0]};
          lba_pkg::MODE_PULSE: begin
            if (level == lba_pkg::LEVEL_ZERO) begin
              state_o.fine = {ref_level, 4'b0};
              state_o.mode = lba_pkg::MODE_STABLE;
            end else if (level == lba_pkg::LEVEL_FULL) begin
              state_o.fine = {lba_pkg::LEVEL_ZERO, 4'b0};
            end else begin
              state_o.fine = {lba_pkg::LEVEL_FULL, 4'b0};
            end
          end
          lba_pkg::MODE_RIPPLE: begin
            state_o.dim  = ripple_dim ^ ripple_down_turn;
            state_o.fine = step_fine(state_i.fine, ripple_dim ^ ripple_down_turn,
                                     lba_pkg::STEP_LARGE, lba_pkg::LEVEL_ZERO,
                                     lba_pkg::LEVEL_FULL);
          end
          default: ;
        endcase
      end
      lba_pkg::OP_SET_LEVEL:  state_o.fine = {event_i.level, 4'b0};
      lba_pkg::OP_SET_MODE:   state_o.mode = event_i.mode;
      lba_pkg::OP_SET_DIR:    state_o.dim  = event_i.dir;
      lba_pkg::OP_TOGGLE_DIR: state_o.dim  = ~state_i.dim;
      // Unused op codes leave the state as it is.
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/led_brightness_animator.sv -----
// Top level of the lamp brightness animator: input register, lamp state register
// that doubles as the result register, and the reference level register.
// Depends on lba_pkg and lba_core.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   op, level, mode, direction, floor, ceil
//   out_     output     out_valid / out_stall brightness, mode, dimming
//   cfg_     input      cfg_wr_en             reference level (8 bits)
//
// One event per cycle sustained while the result is not stalled.
// The input register feeds lba_core, whose next state is loaded into the lamp
// state register that also drives the result ports.
// Reset clears the lamp state, the reference level and both valid flags.
// A stalled result holds the event in the input register; in_stall rises only then.
`default_nettype none

module led_brightness_animator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_level_value,
  input  logic [2:0] in_mode_value,
  input  logic       in_direction_value,
  input  logic [7:0] in_floor_level,
  input  logic [7:0] in_ceil_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_brightness,
  output logic [2:0] out_mode,
  output logic       out_dimming,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic                 ev_valid_r;
  lba_pkg::event_t      ev_r;
  lba_pkg::lamp_state_t state_r;
  lba_pkg::lamp_state_t state_nxt;
  logic                 out_valid_r;
  logic [7:0]           ref_level_r;
  logic                 ev_adv;
  logic                 in_take;

  // An event moves into the state register when the result slot is free.
  assign ev_adv   = ev_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = ev_valid_r && !ev_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        ev_valid_r <= 1'b1;
      end else if (ev_adv) begin
        ev_valid_r <= 1'b0;
      end
    end
    if (in_take) begin
      ev_r.op        <= lba_pkg::op_t'(in_op);
      ev_r.level     <= in_level_value;
      ev_r.mode      <= lba_pkg::mode_t'(in_mode_value);
      ev_r.dir       <= in_direction_value;
      ev_r.floor_lvl <= in_floor_level;
      ev_r.ceil_lvl  <= in_ceil_level;
    end
  end

  // Next-state logic
  lba_core u_core (
    .state_i   (state_r),
    .event_i   (ev_r),
    .ref_level (ref_level_r),
    .state_o   (state_nxt)
  );

  // Lamp state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ev_adv) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reference level register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_level_r <= '0;
    end else if (cfg_wr_en) begin
      ref_level_r <= cfg_wr_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_brightness = state_r.fine[11:4];
  assign out_mode       = state_r.mode;
  assign out_dimming    = state_r.dim;

  // An event that advances always produces a result in the next cycle.
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ev_adv |=> out_valid_r)
    else $error("advancing event produced no result");

  // The lamp state changes only when an event advances.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ev_adv |=> $stable(state_r))
    else $error("lamp state changed without an event");

  // A pulse tick at level zero always returns to stable mode.
  a_pulse_restore: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_adv && (ev_r.op == lba_pkg::OP_TICK) && (state_r.mode == lba_pkg::MODE_PULSE)
     && (state_r.fine[11:4] == lba_pkg::LEVEL_ZERO))
    |=> (state_r.mode == lba_pkg::MODE_STABLE))
    else $error("pulse restore did not return to stable mode");

endmodule

`default_nettype wire
